/* rtl/core/rc4_pkg.sv */
// shared constants and types of the rc4 stream cipher core
package rc4_pkg;

	localparam int DATA_W            = 8;
	localparam int KEY_WORD_W        = 64;
	localparam int KEY_LEN_W         = 5;
	localparam int CFG_IDX_W         = 2;
	localparam int MAX_KEY_BYTES_DEF = 16;
	localparam int SBOX_DEPTH        = 256;
	localparam int SBOX_AW           = 8;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2,
		REG_NONE     = 2'd3
	} cfg_reg_t;

endpackage

/* rtl/core/rc4_stream_if.sv */
// valid/ready channel interfaces for input bytes and result bytes
interface rc4_feed_if;
	logic                       valid;
	logic                       ready;
	logic [rc4_pkg::DATA_W-1:0] data_byte;
	logic                       start_of_message;

	modport source (output valid, output data_byte, output start_of_message, input ready);
	modport sink (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface rc4_result_if;
	logic                       valid;
	logic                       ready;
	logic [rc4_pkg::DATA_W-1:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink (input valid, input data_out, output ready);
endinterface

/* rtl/core/rc4_stream_cipher_core.sv */
// rc4 stream cipher core: key schedule and keystream sequencer over one permutation memory
//
//   channel   kind        payload
//   feed      sink        data_byte[7:0], start_of_message
//   result    source      data_out[7:0]
//   cfg       write port  cfg_idx selects key_bytes_low, key_bytes_high, key_length
//
// a byte passes through the accept, read i, read j, swap write i,
// swap write j with the output read, then the result load (one write and one read memory port)
// start_of_message adds 256 key schedule rounds of 4 memory steps each.
// reset needs no clearing pass: per-entry valid bits make unwritten entries read as their index.
// feed is stalled while a byte is in work; a stalled result holds in the output register and
// the next byte waits in its load step until that beat is taken
module rc4_stream_cipher_core #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rc4_feed_if.sink                          feed,
	rc4_result_if.source                      result,
	input  logic                              cfg_we,
	input  logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rc4_pkg::KEY_WORD_W-1:0]    cfg_wdata
);

	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
	localparam int AW = rc4_pkg::SBOX_AW;
	localparam int DW = rc4_pkg::DATA_W;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_KS_RD_N  = 10'b00_0000_0010,
		ST_KS_RD_A  = 10'b00_0000_0100,
		ST_KS_WR_N  = 10'b00_0000_1000,
		ST_KS_WR_A  = 10'b00_0001_0000,
		ST_RD_I     = 10'b00_0010_0000,
		ST_RD_J     = 10'b00_0100_0000,
		ST_WR_I     = 10'b00_1000_0000,
		ST_WR_J     = 10'b01_0000_0000,
		ST_OUT      = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [rc4_pkg::KEY_WORD_W-1:0] key_lo_q;
	logic [rc4_pkg::KEY_WORD_W-1:0] key_hi_q;
	logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_q;

	logic [DW-1:0]     data_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     n_q;
	logic [AW-1:0]     acc_q;
	logic [KIDX_W-1:0] kidx_q;
	logic [DW-1:0]     tmp_q;
	logic [DW-1:0]     sj_q;
	logic [AW-1:0]     t_q;
	logic              res_valid_q;
	logic [DW-1:0]     res_data_q;

	logic [DW-1:0]             sbox_mem [rc4_pkg::SBOX_DEPTH];
	logic [rc4_pkg::SBOX_DEPTH-1:0] valid_q;
	logic [DW-1:0]             rd_data_q;
	logic [AW-1:0]             rd_addr_q;
	logic                      rd_valid_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          valid_clr;

	logic [DW-1:0]             rd_val;
	logic [rc4_pkg::KEY_LEN_W-1:0] len_eff;
	logic                      kidx_last;
	logic [3:0]                kidx4;
	logic [2*rc4_pkg::KEY_WORD_W-1:0] key_all;
	logic [DW-1:0]             key_byte;
	logic [AW-1:0]             acc_next;
	logic [AW-1:0]             i_next;
	logic [AW-1:0]             j_next;
	logic [AW-1:0]             t_next;
	logic [DW-1:0]             ks;
	logic                      feed_acc;
	logic                      res_load;

	// unwritten entries of the permutation read as the identity
	assign rd_val = rd_valid_q ? rd_data_q : rd_addr_q;

	always_comb begin
		len_eff = key_len_q;
		if (len_eff == '0) begin
			len_eff = 5'd1;
		end else if (len_eff > MAX_LEN) begin
			len_eff = MAX_LEN;
		end
	end

	assign kidx_last = (rc4_pkg::KEY_LEN_W'(kidx_q) == (len_eff - 5'd1));
	assign kidx4     = 4'(kidx_q);
	assign key_all   = {key_hi_q, key_lo_q};
	assign key_byte  = key_all[{kidx4, 3'b000} +: 8];
	assign acc_next  = acc_q + rd_val + key_byte;
	assign i_next    = i_q + 8'd1;
	assign j_next    = j_q + rd_val;
	assign t_next    = tmp_q + sj_q;

	// the swap write of j lands in the same cycle as the output read and is missed by it: forward the swapped values
	always_comb begin
		if (t_q == j_q) begin
			ks = tmp_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = rd_val;
		end
	end

	assign feed.ready   = (state_q == ST_IDLE);
	assign feed_acc     = feed.valid && feed.ready;
	assign res_load     = (state_q == ST_OUT) && (!res_valid_q || result.ready);
	assign result.valid = res_valid_q;
	assign result.data_out = res_data_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = n_q;
		mem_wdata = rd_val;
		mem_re    = 1'b0;
		mem_raddr = n_q;
		valid_clr = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				valid_clr = feed_acc && feed.start_of_message;
			end
			ST_KS_RD_N: begin
				mem_re    = 1'b1;
				mem_raddr = n_q;
			end
			ST_KS_RD_A: begin
				mem_re    = 1'b1;
				mem_raddr = acc_next;
			end
			ST_KS_WR_N: begin
				mem_we    = 1'b1;
				mem_waddr = n_q;
				mem_wdata = rd_val;
			end
			ST_KS_WR_A: begin
				mem_we    = 1'b1;
				mem_waddr = acc_q;
				mem_wdata = tmp_q;
			end
			ST_RD_I: begin
				mem_re    = 1'b1;
				mem_raddr = i_next;
			end
			ST_RD_J: begin
				mem_re    = 1'b1;
				mem_raddr = j_next;
			end
			ST_WR_I: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = rd_val;
			end
			ST_WR_J: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = tmp_q;
				mem_re    = 1'b1;
				mem_raddr = t_next;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sbox_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= sbox_mem[mem_raddr];
			rd_addr_q <= mem_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (valid_clr) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			if (mem_re) begin
				rd_valid_q <= valid_q[mem_raddr];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= rc4_pkg::KEY_LEN_RESET;
		end else if (cfg_we) begin
			unique case (rc4_pkg::cfg_reg_t'(cfg_idx))
				rc4_pkg::REG_KEY_LOW:  key_lo_q  <= cfg_wdata;
				rc4_pkg::REG_KEY_HIGH: key_hi_q  <= cfg_wdata;
				rc4_pkg::REG_KEY_LEN:  key_len_q <= cfg_wdata[rc4_pkg::KEY_LEN_W-1:0];
				rc4_pkg::REG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			kidx_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (feed_acc) begin
						if (feed.start_of_message) begin
							n_q     <= '0;
							acc_q   <= '0;
							kidx_q  <= '0;
							state_q <= ST_KS_RD_N;
						end else begin
							state_q <= ST_RD_I;
						end
					end
				end
				ST_KS_RD_N: begin
					state_q <= ST_KS_RD_A;
				end
				ST_KS_RD_A: begin
					acc_q   <= acc_next;
					state_q <= ST_KS_WR_N;
				end
				ST_KS_WR_N: begin
					state_q <= ST_KS_WR_A;
				end
				ST_KS_WR_A: begin
					n_q    <= n_q + 8'd1;
					kidx_q <= kidx_last ? '0 : kidx_q + 1'b1;
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_RD_I;
					end else begin
						state_q <= ST_KS_RD_N;
					end
				end
				ST_RD_I: begin
					i_q     <= i_next;
					state_q <= ST_RD_J;
				end
				ST_RD_J: begin
					j_q     <= j_next;
					state_q <= ST_WR_I;
				end
				ST_WR_I: begin
					state_q <= ST_WR_J;
				end
				ST_WR_J: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (feed_acc) begin
			data_q <= feed.data_byte;
		end
		if ((state_q == ST_KS_RD_A) || (state_q == ST_RD_J)) begin
			tmp_q <= rd_val;
		end
		if (state_q == ST_WR_I) begin
			sj_q <= rd_val;
		end
		if (state_q == ST_WR_J) begin
			t_q <= t_next;
		end
		if (res_load) begin
			res_data_q <= data_q ^ ks;
		end
	end

endmodule

/* tb/sv/tb_rc4_stream_cipher_core.sv */
// testbench for the rc4 stream cipher core: byte stream checked against a keystream predictor
`timescale 1ns / 100ps

module tb_rc4_stream_cipher_core;
	import rc4_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              start_of_message;
	} feed_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [KEY_WORD_W-1:0] cfg_wdata;

	rc4_feed_if   feed_ch ();
	rc4_result_if result_ch ();

	rc4_stream_cipher_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [DATA_W-1:0]     sbox [SBOX_DEPTH];
	logic [DATA_W-1:0]     ks_i;
	logic [DATA_W-1:0]     ks_j;
	logic [2*KEY_WORD_W-1:0] key_material;
	logic [KEY_LEN_W-1:0]  key_len;

	feed_beat_t        pending_bytes [$];
	logic [DATA_W-1:0] expected_cipher [$];

	int     error_count = 0;
	longint cycle_count = 0;
	longint cycle_budget = 4000;

	int        max_gap = 0;
	int        max_burst = 1;
	logic [15:0] stall_word = 16'h0000;
	int        burst_left;
	int        gap_left;
	logic [3:0] stall_pos;

	function automatic void run_key_schedule();
		int                n;
		int                len;
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] t;
		len = int'(key_len);
		if (len < 1) len = 1;
		if (len > MAX_KEY_BYTES_DEF) len = MAX_KEY_BYTES_DEF;
		for (n = 0; n < SBOX_DEPTH; n++) sbox[n] = n[DATA_W-1:0];
		acc = '0;
		for (n = 0; n < SBOX_DEPTH; n++) begin
			acc = acc + sbox[n] + key_material[8*(n % len) +: 8];
			t = sbox[n];
			sbox[n] = sbox[acc];
			sbox[acc] = t;
		end
		ks_i = '0;
		ks_j = '0;
	endfunction

	function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] din,
			input logic som);
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] pick;
		if (som) run_key_schedule();
		ks_i = ks_i + 8'd1;
		ks_j = ks_j + sbox[ks_i];
		t = sbox[ks_i];
		sbox[ks_i] = sbox[ks_j];
		sbox[ks_j] = t;
		pick = sbox[ks_i] + sbox[ks_j];
		return din ^ sbox[pick];
	endfunction

	// driver: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_ch.valid <= 1'b0;
			feed_ch.data_byte <= '0;
			feed_ch.start_of_message <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (feed_ch.valid && feed_ch.ready) begin
				expected_cipher.push_back(cipher_byte(pending_bytes[0].data_byte,
					pending_bytes[0].start_of_message));
				void'(pending_bytes.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, max_burst);
					gap_left = $urandom_range(0, max_gap);
				end
			end
			if (!(feed_ch.valid && !feed_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					feed_ch.valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					feed_ch.valid <= 1'b1;
					feed_ch.data_byte <= pending_bytes[0].data_byte;
					feed_ch.start_of_message <= pending_bytes[0].start_of_message;
				end else begin
					feed_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: result beats against the oldest expected byte
	always @(posedge clk or negedge arst_n) begin
		logic [DATA_W-1:0] want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_pos <= '0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_cipher.size() == 0) begin
					$display("%0t unexpected result beat: expected none actual %02h",
						$time, result_ch.data_out);
					error_count++;
				end else begin
					want = expected_cipher.pop_front();
					if (result_ch.data_out !== want) begin
						$display("%0t data_out mismatch: expected %02h actual %02h",
							$time, want, result_ch.data_out);
						error_count++;
					end
				end
			end
			result_ch.ready <= !stall_word[stall_pos];
			stall_pos <= stall_pos + 4'd1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("[rc4_stream_cipher_core] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [KEY_WORD_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_KEY_LOW: begin
				key_material[KEY_WORD_W-1:0] = value;
			end
			REG_KEY_HIGH: begin
				key_material[2*KEY_WORD_W-1:KEY_WORD_W] = value;
			end
			REG_KEY_LEN: begin
				key_len = value[KEY_LEN_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_byte(input logic [DATA_W-1:0] din, input logic som);
		feed_beat_t beat;
		beat.data_byte = din;
		beat.start_of_message = som;
		pending_bytes.push_back(beat);
		cycle_budget += 4 * (8 + max_gap + 16) + (som ? 4 * 1100 : 0);
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_cipher.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_idling(input int gap, input int burst, input logic [15:0] pattern);
		max_gap = gap;
		max_burst = burst;
		stall_word = pattern & ~(16'h0001 << $urandom_range(0, 15));
	endtask

	initial begin
		int          random_bytes;
		int          msg_count;
		int          msg_len;
		int          m;
		int          k;
		int          sel;
		logic        som;
		logic [KEY_WORD_W-1:0] v;
		logic [7:0]  plain [9];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_KEY_LOW;
		cfg_wdata = '0;
		feed_ch.valid = 1'b0;
		feed_ch.data_byte = '0;
		feed_ch.start_of_message = 1'b0;
		result_ch.ready = 1'b0;
		for (k = 0; k < SBOX_DEPTH; k++) sbox[k] = k[DATA_W-1:0];
		ks_i = '0;
		ks_j = '0;
		key_material = '0;
		key_len = KEY_LEN_RESET;
		plain = '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity permutation before any start
		set_idling(0, 1, 16'h0000);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hA5, 1'b0);
		queue_byte(8'h5A, 1'b0);
		wait_drained();

		// known three byte key
		set_idling(3, 4, 16'hA5A5);
		write_reg(REG_KEY_LOW, 64'h0000_0000_0079_654B);
		write_reg(REG_KEY_LEN, 64'd3);
		for (k = 0; k < 9; k++) queue_byte(plain[k], k == 0);
		wait_drained();

		// zero key length acts as one
		write_reg(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_LEN, 64'd0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h3C, 1'b0);
		wait_drained();

		// oversize key length saturates
		set_idling(0, 1, 16'hFFFE);
		write_reg(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_KEY_LEN, {$urandom, $urandom} | 64'h1F);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h81, 1'b0);
		wait_drained();

		// unmapped index ignored, back to back starts
		set_idling(1, 2, 16'h0F0F);
		write_reg(REG_KEY_LEN, 64'd16);
		write_reg(REG_NONE, {$urandom, $urandom});
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h7E, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h01, 1'b1);
		wait_drained();

		random_bytes = 0;
		while (random_bytes < 900) begin
			case ($urandom_range(0, 3))
				0: set_idling(0, 1, 16'h0000);
				1: set_idling($urandom_range(1, 8), $urandom_range(1, 16), 16'h0000);
				2: set_idling(0, 1, 16'($urandom));
				default: set_idling($urandom_range(1, 8), $urandom_range(1, 16),
					16'($urandom));
			endcase
			if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_LOW, {$urandom, $urandom});
			if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_HIGH, {$urandom, $urandom});
			if ($urandom_range(0, 2) != 0) begin
				sel = $urandom_range(0, 7);
				v = {$urandom, $urandom};
				case (sel)
					0: v[KEY_LEN_W-1:0] = 5'd1;
					1: v[KEY_LEN_W-1:0] = 5'd16;
					2: v[KEY_LEN_W-1:0] = 5'd0;
					3: v[KEY_LEN_W-1:0] = 5'($urandom_range(17, 31));
					default: v[KEY_LEN_W-1:0] = 5'($urandom_range(1, 16));
				endcase
				write_reg(REG_KEY_LEN, v);
			end
			if ($urandom_range(0, 7) == 0) write_reg(REG_NONE, {$urandom, $urandom});
			msg_count = $urandom_range(1, 4);
			for (m = 0; m < msg_count; m++) begin
				msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 48);
				// a phase may continue the previous stream without a new start
				som = !(m == 0 && $urandom_range(0, 7) == 0);
				for (k = 0; k < msg_len; k++) begin
					queue_byte(8'($urandom_range(0, 255)), (k == 0) ? som : 1'b0);
					random_bytes++;
				end
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("[rc4_stream_cipher_core] OK");
		end else begin
			$display("[rc4_stream_cipher_core] ERROR");
		end
		$finish;
	end

endmodule
